[hdl/espl_pkg.sv]
// Shared types and constants of the encoder speed loop.
`timescale 1ns / 1ps
`default_nettype none
package espl_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TARGET_RPM = 3'd0;
   localparam logic [2:0] CSR_MAX_RPM    = 3'd1;
   localparam logic [2:0] CSR_TICKS_REV  = 3'd2;
   localparam logic [2:0] CSR_GAIN_P     = 3'd3;
   localparam logic [2:0] CSR_GAIN_I     = 3'd4;
   localparam logic [2:0] CSR_GAIN_D     = 3'd5;
   localparam logic [2:0] CSR_PID_ON     = 3'd6;

   // Field and datapath widths.
   localparam int RPM_W      = 24;
   localparam int MAX_W      = 23;
   localparam int TPR_W      = 16;
   localparam int GAIN_W     = 24;
   localparam int ERR_W      = 25;
   localparam int DIFF_W     = 26;
   localparam int INTEG_W    = 48;
   localparam int IQ_W       = 39;
   localparam int DERIV_W    = 36;
   localparam int ACC_W      = 64;
   localparam int NBITS_W    = 7;

   // Arithmetic constants and the multiplier widths they need.
   localparam logic [15:0] RPM_SCALE  = 16'd60000;
   localparam int          SCALE_BITS = 16;
   localparam logic [12:0] ALPHA_Q16  = 13'd6554;
   localparam int          ALPHA_BITS = 13;
   localparam logic [9:0]  MS_PER_S   = 10'd1000;
   localparam int          MS_BITS    = 10;

   // Shared serial unit operations.
   typedef enum logic {
      ARITH_MUL,
      ARITH_DIV
   } arith_op_type;

   typedef struct packed {
      logic                 start;
      arith_op_type         op;
      logic                 neg;
      logic [NBITS_W-1:0]   nbits;
   } arith_cmd_type;

   function automatic arith_cmd_type arith_cmd(arith_op_type op, logic neg,
                                               logic [NBITS_W-1:0] nbits);
      arith_cmd_type c;
      c.start = 1'b1;
      c.op    = op;
      c.neg   = neg;
      c.nbits = nbits;
      return c;
   endfunction

endpackage
`default_nettype wire

[hdl/espl_if.sv]
// Valid/ready channel interfaces for control ticks and drive results.
`timescale 1ns / 1ps
`default_nettype none
interface espl_req_if;
   logic               valid;
   logic               ready;
   logic        [31:0] time_ms;
   logic signed [31:0] encoder_count;
   modport source(output valid, time_ms, encoder_count, input ready);
   modport sink(input valid, time_ms, encoder_count, output ready);
endinterface

interface espl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive_command;
   logic signed [23:0] filtered_rpm;
   modport source(output valid, drive_command, filtered_rpm, input ready);
   modport sink(input valid, drive_command, filtered_rpm, output ready);
endinterface
`default_nettype wire

[hdl/espl_arith.sv]
// Shared bit-serial multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module espl_arith
   import espl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire arith_cmd_type     cmd,
   input  wire logic [ACC_W-1:0]  opa,
   input  wire logic [ACC_W-1:0]  opb,
   output logic                   done,
   output logic [ACC_W-1:0]       result
);

   typedef enum logic [1:0] {
      A_IDLE,
      A_RUN,
      A_FIX
   } state_type;

   state_type          state_ff;
   arith_op_type       op_ff;
   logic               neg_ff;
   logic               done_ff;
   logic [NBITS_W-1:0] cnt_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   ra_ff;
   logic [ACC_W-1:0]   rb_ff;
   logic [ACC_W-1:0]   den_ff;

   logic [ACC_W-1:0]   shl_in;
   logic [ACC_W:0]     trial_in;
   logic [ACC_W-1:0]   madd_in;

   // Partial remainder with the next dividend bit, its trial subtract and the product add.
   always_comb begin
      shl_in   = {rb_ff[ACC_W-2:0], ra_ff[ACC_W-1]};
      trial_in = {1'b0, shl_in} - {1'b0, den_ff};
      madd_in  = acc_ff + ra_ff;
   end

   // Multiply: shift-and-add over the multiplier bits, LSB first.
   // Divide: one quotient bit per cycle, dividend taken MSB first.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            A_IDLE: begin
               if (cmd.start) begin
                  op_ff    <= cmd.op;
                  neg_ff   <= cmd.neg;
                  cnt_ff   <= cmd.nbits;
                  acc_ff   <= '0;
                  ra_ff    <= opa;
                  rb_ff    <= (cmd.op == ARITH_MUL) ? opb : '0;
                  den_ff   <= opb;
                  state_ff <= A_RUN;
               end
            end
            A_RUN: begin
               case (op_ff)
                  ARITH_MUL: begin
                     if (rb_ff[0]) begin
                        acc_ff <= madd_in;
                     end
                     rb_ff <= rb_ff >> 1;
                  end
                  ARITH_DIV: begin
                     if (!trial_in[ACC_W]) begin
                        rb_ff  <= trial_in[ACC_W-1:0];
                        acc_ff <= {acc_ff[ACC_W-2:0], 1'b1};
                     end else begin
                        rb_ff  <= shl_in;
                        acc_ff <= {acc_ff[ACC_W-2:0], 1'b0};
                     end
                  end
                  default: begin
                  end
               endcase
               ra_ff  <= ra_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == NBITS_W'(1)) begin
                  state_ff <= A_FIX;
               end
            end
            A_FIX: begin
               acc_ff   <= neg_ff ? (-acc_ff) : acc_ff;
               done_ff  <= 1'b1;
               state_ff <= A_IDLE;
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule
`default_nettype wire

[hdl/encoder_speed_pid_loop_top.sv]
// Top level of the encoder speed loop: measurement, smoothing, PID and drive scaling.
`timescale 1ns / 1ps
`default_nettype none
// Each item is one control tick (millisecond timestamp and encoder count). A tick whose
// timestamp equals the previous one is consumed without a result and changes nothing; with
// ticks per revolution at zero the tick only records time and count. Otherwise the block
// measures speed in rpm, smooths it, and returns one item with the drive command and the
// smoothed speed. All multiplies and divides run one bit per cycle in a single shared
// serial unit: five serial operations with the PID stage off, twelve with it on; a saturated
// or zero drive skips the last division. A new item is taken as soon as the sequencer is
// idle, even while the previous result still waits to be taken.
module encoder_speed_pid_loop_top
   import espl_pkg::*;
#(
   parameter int RPM_FRAC_BITS  = 8,
   parameter int GAIN_FRAC_BITS = 16,
   parameter int COUNT_WIDTH    = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   espl_req_if.sink         req_ch,
   espl_rsp_if.source       rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   localparam int NUM_BITS    = COUNT_WIDTH + SCALE_BITS + RPM_FRAC_BITS;
   localparam int NUM_ALIGN   = ACC_W - COUNT_WIDTH - SCALE_BITS;
   localparam int Q15_BITS    = MAX_W + GAIN_FRAC_BITS + 15;
   localparam int Q15_ALIGN   = ACC_W - MAX_W - GAIN_FRAC_BITS;
   localparam int DERIV_ALIGN = ACC_W - DERIV_W;
   localparam int IQ_ALIGN    = ACC_W - INTEG_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEN,
      S_NUM,
      S_RPM,
      S_FILT,
      S_INTEG,
      S_DIFF,
      S_DERIV,
      S_IQ,
      S_PTERM,
      S_ITERM,
      S_DTERM,
      S_SCALE,
      S_DRIVE,
      S_OUT
   } state_type;

   // Configuration registers.
   logic signed [RPM_W-1:0]  cfg_target_ff;
   logic [MAX_W-1:0]         cfg_max_ff;
   logic [TPR_W-1:0]         cfg_tpr_ff;
   logic signed [GAIN_W-1:0] cfg_gp_ff;
   logic signed [GAIN_W-1:0] cfg_gi_ff;
   logic signed [GAIN_W-1:0] cfg_gd_ff;
   logic                     cfg_pid_ff;

   // Loop state kept between items.
   state_type                state_ff;
   logic [31:0]              last_time_ff;
   logic [COUNT_WIDTH-1:0]   last_count_ff;
   logic signed [RPM_W-1:0]  sm_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [ERR_W-1:0]  prev_err_ff;

   // Per item working registers.
   logic [31:0]              dt_ff;
   logic signed [RPM_W-1:0]  target_ff;
   logic [COUNT_WIDTH-1:0]   mag_ff;
   logic                     rneg_ff;
   logic [47:0]              den_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [DERIV_W-1:0] deriv_ff;
   logic signed [IQ_W-1:0]   iq_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [15:0]       drive_ff;
   arith_cmd_type            cmd_ff;
   logic [ACC_W-1:0]         opa_ff;
   logic [ACC_W-1:0]         opb_ff;

   // Result register.
   logic                     rsp_valid_ff;
   logic signed [15:0]       rsp_drive_ff;
   logic signed [RPM_W-1:0]  rsp_rpm_ff;

   logic                     arith_done;
   logic [ACC_W-1:0]         arith_res;

   logic [31:0]              dt_in;
   logic [COUNT_WIDTH-1:0]   cnt_in;
   logic [COUNT_WIDTH-1:0]   delta_in;
   logic [COUNT_WIDTH-1:0]   dmag_in;
   logic signed [RPM_W:0]    tgt_ext_in;
   logic signed [RPM_W:0]    max_ext_in;
   logic signed [RPM_W:0]    nmax_in;
   logic signed [RPM_W-1:0]  tgt_in;
   logic signed [RPM_W-1:0]  raw_in;
   logic signed [ERR_W-1:0]  fdiff_in;
   logic signed [ACC_W-1:0]  fsum_in;
   logic signed [47:0]       fshift_in;
   logic signed [RPM_W-1:0]  fnew_in;
   logic signed [ERR_W-1:0]  err_in;
   logic [ERR_W-1:0]         emag_in;
   logic signed [ACC_W-1:0]  isum_in;
   logic signed [INTEG_W-1:0] isat_in;
   logic signed [DIFF_W-1:0] diff_in;
   logic [ACC_W-1:0]         dres_abs_in;
   logic [INTEG_W-1:0]       imag_in;
   logic [GAIN_W-1:0]        gpm_in;
   logic [GAIN_W-1:0]        gim_in;
   logic [GAIN_W-1:0]        gdm_in;
   logic [ACC_W-1:0]         dden_in;
   logic [ACC_W-1:0]         drv_abs_in;

   espl_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_ff),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .done   (arith_done),
      .result (arith_res)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_target_ff <= '0;
         cfg_max_ff    <= MAX_W'(256);
         cfg_tpr_ff    <= TPR_W'(1);
         cfg_gp_ff     <= '0;
         cfg_gi_ff     <= '0;
         cfg_gd_ff     <= '0;
         cfg_pid_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_RPM: cfg_target_ff <= csr_wdata;
            CSR_MAX_RPM:    cfg_max_ff    <= csr_wdata[MAX_W-1:0];
            CSR_TICKS_REV:  cfg_tpr_ff    <= csr_wdata[TPR_W-1:0];
            CSR_GAIN_P:     cfg_gp_ff     <= csr_wdata;
            CSR_GAIN_I:     cfg_gi_ff     <= csr_wdata;
            CSR_GAIN_D:     cfg_gd_ff     <= csr_wdata;
            CSR_PID_ON:     cfg_pid_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Narrow glue between the serial operations.
   always_comb begin
      // Elapsed time, encoder delta and its magnitude.
      dt_in    = req_ch.time_ms - last_time_ff;
      cnt_in   = req_ch.encoder_count[COUNT_WIDTH-1:0];
      delta_in = cnt_in - last_count_ff;
      dmag_in  = delta_in[COUNT_WIDTH-1] ? (-delta_in) : delta_in;

      // Target clamped to plus or minus the maximum speed.
      tgt_ext_in = {cfg_target_ff[RPM_W-1], cfg_target_ff};
      max_ext_in = {2'b00, cfg_max_ff};
      nmax_in    = -max_ext_in;
      if (tgt_ext_in > max_ext_in) begin
         tgt_in = max_ext_in[RPM_W-1:0];
      end else if (tgt_ext_in < nmax_in) begin
         tgt_in = nmax_in[RPM_W-1:0];
      end else begin
         tgt_in = cfg_target_ff;
      end

      // Signed, saturated raw speed from the quotient.
      if (|arith_res[ACC_W-1:RPM_W-1]) begin
         raw_in = rneg_ff ? {1'b1, {(RPM_W-1){1'b0}}} : {1'b0, {(RPM_W-1){1'b1}}};
      end else begin
         raw_in = rneg_ff ? (-arith_res[RPM_W-1:0]) : arith_res[RPM_W-1:0];
      end
      fdiff_in = {raw_in[RPM_W-1], raw_in} - {sm_ff[RPM_W-1], sm_ff};

      // Filter: alpha*(raw - old) + old*65536, rounded and floored.
      fsum_in   = $signed(arith_res) + {{(ACC_W-RPM_W-16){sm_ff[RPM_W-1]}}, sm_ff, 16'h0000}
                  + 64'sd32768;
      fshift_in = fsum_in[ACC_W-1:16];
      if (fshift_in > 48'sd8388607) begin
         fnew_in = {1'b0, {(RPM_W-1){1'b1}}};
      end else if (fshift_in < -48'sd8388608) begin
         fnew_in = {1'b1, {(RPM_W-1){1'b0}}};
      end else begin
         fnew_in = fshift_in[RPM_W-1:0];
      end
      err_in  = {target_ff[RPM_W-1], target_ff} - {fnew_in[RPM_W-1], fnew_in};
      emag_in = err_in[ERR_W-1] ? (-err_in) : err_in;

      // Saturating integral update and error difference.
      isum_in = {{(ACC_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff} + $signed(arith_res);
      if (isum_in > 64'sh0000_7FFF_FFFF_FFFF) begin
         isat_in = {1'b0, {(INTEG_W-1){1'b1}}};
      end else if (isum_in < -64'sh0000_8000_0000_0000) begin
         isat_in = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         isat_in = isum_in[INTEG_W-1:0];
      end
      diff_in = {err_ff[ERR_W-1], err_ff} - {prev_err_ff[ERR_W-1], prev_err_ff};

      // Magnitudes for the serial unit, which negates the result itself.
      dres_abs_in = arith_res[ACC_W-1] ? (-arith_res) : arith_res;
      imag_in     = integ_ff[INTEG_W-1] ? (-integ_ff) : integ_ff;
      gpm_in      = cfg_gp_ff[GAIN_W-1] ? (-cfg_gp_ff) : cfg_gp_ff;
      gim_in      = cfg_gi_ff[GAIN_W-1] ? (-cfg_gi_ff) : cfg_gi_ff;
      gdm_in      = cfg_gd_ff[GAIN_W-1] ? (-cfg_gd_ff) : cfg_gd_ff;

      // Drive scaling: the numerator sits in acc_ff.
      dden_in    = cfg_pid_ff ? (ACC_W'(cfg_max_ff) << GAIN_FRAC_BITS) : ACC_W'(cfg_max_ff);
      drv_abs_in = acc_ff[ACC_W-1] ? (-acc_ff) : acc_ff;
   end

   // Sequencer: launches each serial operation and folds in its result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_time_ff  <= '0;
         last_count_ff <= '0;
         sm_ff         <= '0;
         integ_ff      <= '0;
         prev_err_ff   <= '0;
         cmd_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cmd_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid && (dt_in != 32'd0)) begin
                  last_time_ff  <= req_ch.time_ms;
                  last_count_ff <= cnt_in;
                  if (cfg_tpr_ff != '0) begin
                     dt_ff     <= dt_in;
                     target_ff <= tgt_in;
                     mag_ff    <= dmag_in;
                     rneg_ff   <= delta_in[COUNT_WIDTH-1] != tgt_in[RPM_W-1];
                     cmd_ff    <= arith_cmd(ARITH_MUL, 1'b0, NBITS_W'(TPR_W));
                     opa_ff    <= ACC_W'(dt_in);
                     opb_ff    <= ACC_W'(cfg_tpr_ff);
                     state_ff  <= S_DEN;
                  end
               end
            end
            S_DEN: begin
               if (arith_done) begin
                  den_ff   <= arith_res[47:0];
                  cmd_ff   <= arith_cmd(ARITH_MUL, 1'b0, NBITS_W'(SCALE_BITS));
                  opa_ff   <= ACC_W'(mag_ff);
                  opb_ff   <= ACC_W'(RPM_SCALE);
                  state_ff <= S_NUM;
               end
            end
            S_NUM: begin
               if (arith_done) begin
                  cmd_ff   <= arith_cmd(ARITH_DIV, 1'b0, NBITS_W'(NUM_BITS));
                  opa_ff   <= arith_res << NUM_ALIGN;
                  opb_ff   <= ACC_W'(den_ff);
                  state_ff <= S_RPM;
               end
            end
            S_RPM: begin
               if (arith_done) begin
                  cmd_ff   <= arith_cmd(ARITH_MUL, 1'b0, NBITS_W'(ALPHA_BITS));
                  opa_ff   <= {{(ACC_W-ERR_W){fdiff_in[ERR_W-1]}}, fdiff_in};
                  opb_ff   <= ACC_W'(ALPHA_Q16);
                  state_ff <= S_FILT;
               end
            end
            S_FILT: begin
               if (arith_done) begin
                  sm_ff <= fnew_in;
                  if (cfg_pid_ff) begin
                     err_ff   <= err_in;
                     cmd_ff   <= arith_cmd(ARITH_MUL, err_in[ERR_W-1], NBITS_W'(ERR_W));
                     opa_ff   <= ACC_W'(dt_ff);
                     opb_ff   <= ACC_W'(emag_in);
                     state_ff <= S_INTEG;
                  end else begin
                     acc_ff   <= {{(ACC_W-RPM_W){target_ff[RPM_W-1]}}, target_ff};
                     state_ff <= S_SCALE;
                  end
               end
            end
            S_INTEG: begin
               if (arith_done) begin
                  integ_ff <= isat_in;
                  cmd_ff   <= arith_cmd(ARITH_MUL, 1'b0, NBITS_W'(MS_BITS));
                  opa_ff   <= {{(ACC_W-DIFF_W){diff_in[DIFF_W-1]}}, diff_in};
                  opb_ff   <= ACC_W'(MS_PER_S);
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF: begin
               if (arith_done) begin
                  cmd_ff   <= arith_cmd(ARITH_DIV, arith_res[ACC_W-1], NBITS_W'(DERIV_W));
                  opa_ff   <= dres_abs_in << DERIV_ALIGN;
                  opb_ff   <= ACC_W'(dt_ff);
                  state_ff <= S_DERIV;
               end
            end
            S_DERIV: begin
               if (arith_done) begin
                  deriv_ff    <= arith_res[DERIV_W-1:0];
                  prev_err_ff <= err_ff;
                  cmd_ff      <= arith_cmd(ARITH_DIV, integ_ff[INTEG_W-1], NBITS_W'(INTEG_W));
                  opa_ff      <= ACC_W'(imag_in) << IQ_ALIGN;
                  opb_ff      <= ACC_W'(MS_PER_S);
                  state_ff    <= S_IQ;
               end
            end
            S_IQ: begin
               if (arith_done) begin
                  iq_ff    <= arith_res[IQ_W-1:0];
                  cmd_ff   <= arith_cmd(ARITH_MUL, cfg_gp_ff[GAIN_W-1], NBITS_W'(GAIN_W));
                  opa_ff   <= {{(ACC_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
                  opb_ff   <= ACC_W'(gpm_in);
                  state_ff <= S_PTERM;
               end
            end
            S_PTERM: begin
               if (arith_done) begin
                  acc_ff   <= $signed(arith_res);
                  cmd_ff   <= arith_cmd(ARITH_MUL, cfg_gi_ff[GAIN_W-1], NBITS_W'(GAIN_W));
                  opa_ff   <= {{(ACC_W-IQ_W){iq_ff[IQ_W-1]}}, iq_ff};
                  opb_ff   <= ACC_W'(gim_in);
                  state_ff <= S_ITERM;
               end
            end
            S_ITERM: begin
               if (arith_done) begin
                  acc_ff   <= acc_ff + $signed(arith_res);
                  cmd_ff   <= arith_cmd(ARITH_MUL, cfg_gd_ff[GAIN_W-1], NBITS_W'(GAIN_W));
                  opa_ff   <= {{(ACC_W-DERIV_W){deriv_ff[DERIV_W-1]}}, deriv_ff};
                  opb_ff   <= ACC_W'(gdm_in);
                  state_ff <= S_DTERM;
               end
            end
            S_DTERM: begin
               if (arith_done) begin
                  acc_ff   <= acc_ff + $signed(arith_res);
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               // Zero and full-scale drives need no division.
               if (acc_ff == '0) begin
                  drive_ff <= '0;
                  state_ff <= S_OUT;
               end else if (drv_abs_in >= dden_in) begin
                  drive_ff <= acc_ff[ACC_W-1] ? 16'sh8000 : 16'sh7FFF;
                  state_ff <= S_OUT;
               end else begin
                  cmd_ff   <= arith_cmd(ARITH_DIV, acc_ff[ACC_W-1], NBITS_W'(Q15_BITS));
                  opa_ff   <= drv_abs_in << Q15_ALIGN;
                  opb_ff   <= dden_in;
                  state_ff <= S_DRIVE;
               end
            end
            S_DRIVE: begin
               if (arith_done) begin
                  drive_ff <= arith_res[15:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_drive_ff <= drive_ff;
                  rsp_rpm_ff   <= sm_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.drive_command = rsp_drive_ff;
   assign rsp_ch.filtered_rpm  = rsp_rpm_ff;

   // A tick with fresh time records its timestamp.
   a_time_recorded: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.time_ms != last_time_ff))
      |=> (last_time_ff == $past(req_ch.time_ms)))
      else $error("timestamp of an accepted item not recorded");

   // A tick with no elapsed time leaves the filter alone and keeps the block idle.
   a_zero_dt: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.time_ms == last_time_ff))
      |=> ($stable(sm_ff) && (state_ff == S_IDLE)))
      else $error("zero elapsed time changed the loop state");

   // The serial unit only finishes while the sequencer waits for it.
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> ((state_ff != S_IDLE) && (state_ff != S_SCALE) && (state_ff != S_OUT)))
      else $error("serial unit finished with no operation outstanding");

endmodule
`default_nettype wire
